>>> rtl/sle_pkg.sv
// Shared types and codes for the sequential list engine.
`default_nettype none

package sle_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_BACK   = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_INSERT     = 3'd4,
        ACT_ERASE      = 3'd5,
        ACT_AMEND      = 3'd6,
        ACT_FIND       = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHUP_CHK,
        S_SHUP_WR,
        S_SHDN_CHK,
        S_SHDN_WR,
        S_FIND_CHK,
        S_FIND_CMP
    } state_t;

    typedef enum logic [1:0] {
        TGT_POS,
        TGT_CNT,
        TGT_ZERO
    } tgt_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_CNT,
        IDX_LOAD_TGT,
        IDX_DEC,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_DEC,
        RD_INC
    } rd_sel_t;

    typedef enum logic [1:0] {
        WD_IN,
        WD_VAL,
        WD_SHIFT
    } wd_sel_t;

    typedef enum logic {
        WA_IDX,
        WA_POS
    } wa_sel_t;

    typedef struct packed {
        logic     load;
        tgt_sel_t tgt_sel;
        idx_op_t  idx_op;
        logic     mem_rd;
        rd_sel_t  rd_sel;
        logic     mem_wr;
        wd_sel_t  wd_sel;
        wa_sel_t  wa_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_load;
        status_t  res_status;
        logic     res_found;
    } sle_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
        logic idx_eq_tgt;
        logic idx_last;
        logic idx_end;
        logic match;
    } sle_stat_t;

endpackage

`default_nettype wire

>>> rtl/sle_ctrl.sv
// Controller state machine for the sequential list engine.
`default_nettype none

module sle_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        action,
    input  wire sle_pkg::sle_stat_t stat,
    output sle_pkg::sle_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);

    sle_pkg::state_t  state_reg;
    sle_pkg::state_t  state_next;
    logic             done_reg;
    sle_pkg::action_t act;

    assign act  = sle_pkg::action_t'(action);
    assign busy = (state_reg != sle_pkg::S_IDLE);
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sle_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.res_load;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sle_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (act)
                        sle_pkg::ACT_PUSH_BACK, sle_pkg::ACT_PUSH_FRONT:
                        begin
                            if (!stat.full)
                                state_next = sle_pkg::S_SHUP_CHK;
                        end
                        sle_pkg::ACT_INSERT:
                        begin
                            if (!stat.full && !stat.pos_gt_cnt)
                                state_next = sle_pkg::S_SHUP_CHK;
                        end
                        sle_pkg::ACT_POP_FRONT:
                        begin
                            if (!stat.empty)
                                state_next = sle_pkg::S_SHDN_CHK;
                        end
                        sle_pkg::ACT_ERASE:
                        begin
                            if (!stat.empty && !stat.pos_ge_cnt)
                                state_next = sle_pkg::S_SHDN_CHK;
                        end
                        sle_pkg::ACT_FIND:
                            state_next = sle_pkg::S_FIND_CHK;
                        sle_pkg::ACT_POP_BACK, sle_pkg::ACT_AMEND:
                            state_next = sle_pkg::S_IDLE;
                    endcase
                end
            end
            sle_pkg::S_SHUP_CHK:
                state_next = stat.idx_eq_tgt ? sle_pkg::S_IDLE : sle_pkg::S_SHUP_WR;
            sle_pkg::S_SHUP_WR:
                state_next = sle_pkg::S_SHUP_CHK;
            sle_pkg::S_SHDN_CHK:
                state_next = stat.idx_last ? sle_pkg::S_IDLE : sle_pkg::S_SHDN_WR;
            sle_pkg::S_SHDN_WR:
                state_next = sle_pkg::S_SHDN_CHK;
            sle_pkg::S_FIND_CHK:
                state_next = stat.idx_end ? sle_pkg::S_IDLE : sle_pkg::S_FIND_CMP;
            sle_pkg::S_FIND_CMP:
                state_next = stat.match ? sle_pkg::S_IDLE : sle_pkg::S_FIND_CHK;
            default:
                state_next = sle_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.tgt_sel    = sle_pkg::TGT_POS;
        cmd.idx_op     = sle_pkg::IDX_HOLD;
        cmd.rd_sel     = sle_pkg::RD_IDX;
        cmd.wd_sel     = sle_pkg::WD_IN;
        cmd.wa_sel     = sle_pkg::WA_IDX;
        cmd.res_status = sle_pkg::ST_OK;
        unique case (state_reg)
            sle_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (act)
                        sle_pkg::ACT_PUSH_BACK, sle_pkg::ACT_PUSH_FRONT:
                        begin
                            cmd.tgt_sel = (act == sle_pkg::ACT_PUSH_BACK) ?
                                          sle_pkg::TGT_CNT : sle_pkg::TGT_ZERO;
                            cmd.idx_op  = sle_pkg::IDX_LOAD_CNT;
                            if (stat.full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sle_pkg::ST_FULL;
                            end
                        end
                        sle_pkg::ACT_INSERT:
                        begin
                            cmd.tgt_sel = sle_pkg::TGT_POS;
                            cmd.idx_op  = sle_pkg::IDX_LOAD_CNT;
                            if (stat.full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sle_pkg::ST_FULL;
                            end
                            else if (stat.pos_gt_cnt)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sle_pkg::ST_RANGE;
                            end
                        end
                        sle_pkg::ACT_POP_BACK:
                        begin
                            cmd.res_load = 1'b1;
                            if (stat.empty)
                                cmd.res_status = sle_pkg::ST_EMPTY;
                            else
                                cmd.cnt_dec = 1'b1;
                        end
                        sle_pkg::ACT_POP_FRONT:
                        begin
                            cmd.tgt_sel = sle_pkg::TGT_ZERO;
                            cmd.idx_op  = sle_pkg::IDX_LOAD_TGT;
                            if (stat.empty)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sle_pkg::ST_EMPTY;
                            end
                        end
                        sle_pkg::ACT_ERASE:
                        begin
                            cmd.tgt_sel = sle_pkg::TGT_POS;
                            cmd.idx_op  = sle_pkg::IDX_LOAD_TGT;
                            if (stat.empty)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sle_pkg::ST_EMPTY;
                            end
                            else if (stat.pos_ge_cnt)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sle_pkg::ST_RANGE;
                            end
                        end
                        sle_pkg::ACT_AMEND:
                        begin
                            cmd.res_load = 1'b1;
                            if (stat.empty)
                                cmd.res_status = sle_pkg::ST_EMPTY;
                            else if (stat.pos_ge_cnt)
                                cmd.res_status = sle_pkg::ST_RANGE;
                            else
                            begin
                                cmd.mem_wr = 1'b1;
                                cmd.wd_sel = sle_pkg::WD_IN;
                                cmd.wa_sel = sle_pkg::WA_POS;
                            end
                        end
                        sle_pkg::ACT_FIND:
                        begin
                            cmd.tgt_sel = sle_pkg::TGT_ZERO;
                            cmd.idx_op  = sle_pkg::IDX_LOAD_TGT;
                        end
                    endcase
                end
            end
            sle_pkg::S_SHUP_CHK:
            begin
                if (stat.idx_eq_tgt)
                begin
                    cmd.mem_wr   = 1'b1;
                    cmd.wd_sel   = sle_pkg::WD_VAL;
                    cmd.wa_sel   = sle_pkg::WA_IDX;
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_load = 1'b1;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = sle_pkg::RD_DEC;
                end
            end
            sle_pkg::S_SHUP_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wd_sel = sle_pkg::WD_SHIFT;
                cmd.wa_sel = sle_pkg::WA_IDX;
                cmd.idx_op = sle_pkg::IDX_DEC;
            end
            sle_pkg::S_SHDN_CHK:
            begin
                if (stat.idx_last)
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.res_load = 1'b1;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = sle_pkg::RD_INC;
                end
            end
            sle_pkg::S_SHDN_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wd_sel = sle_pkg::WD_SHIFT;
                cmd.wa_sel = sle_pkg::WA_IDX;
                cmd.idx_op = sle_pkg::IDX_INC;
            end
            sle_pkg::S_FIND_CHK:
            begin
                if (stat.idx_end)
                    cmd.res_load = 1'b1;
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = sle_pkg::RD_IDX;
                end
            end
            sle_pkg::S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.res_load  = 1'b1;
                    cmd.res_found = 1'b1;
                end
                else
                    cmd.idx_op = sle_pkg::IDX_INC;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sle_datapath.sv
// Datapath of the sequential list engine: entry memory, count, index and result registers.
`default_nettype none

module sle_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sle_pkg::sle_cmd_t  cmd,
    input  wire logic [6:0]         position,
    input  wire logic signed [31:0] value,
    output sle_pkg::sle_stat_t      stat,
    output logic [1:0]              status,
    output logic                    found,
    output logic [5:0]              found_index,
    output logic [6:0]              count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > 7) ? CW : 7;

    logic signed [31:0] mem [CAPACITY];

    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic [CW-1:0]      tgt_reg;
    logic [CW-1:0]      sel_pos;
    logic signed [31:0] val_reg;
    logic signed [31:0] rd_data_reg;
    logic [1:0]         status_reg;
    logic               found_reg;
    logic [5:0]         fidx_reg;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [CW:0]        idx_plus;

    always_comb
    begin
        unique case (cmd.tgt_sel)
            sle_pkg::TGT_POS:  sel_pos = CW'(position);
            sle_pkg::TGT_CNT:  sel_pos = cnt_reg;
            sle_pkg::TGT_ZERO: sel_pos = '0;
            default:           sel_pos = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.idx_op)
            sle_pkg::IDX_HOLD:     idx_next = idx_reg;
            sle_pkg::IDX_LOAD_CNT: idx_next = cnt_reg;
            sle_pkg::IDX_LOAD_TGT: idx_next = sel_pos;
            sle_pkg::IDX_DEC:      idx_next = idx_reg - 1'b1;
            sle_pkg::IDX_INC:      idx_next = idx_reg + 1'b1;
            default:               idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        priority if (cmd.cnt_inc)
            cnt_next = cnt_reg + 1'b1;
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            sle_pkg::RD_IDX: rd_addr = idx_reg[AW-1:0];
            sle_pkg::RD_DEC: rd_addr = AW'(idx_reg - 1'b1);
            sle_pkg::RD_INC: rd_addr = AW'(idx_reg + 1'b1);
            default:         rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        unique case (cmd.wd_sel)
            sle_pkg::WD_IN:    wr_data = value;
            sle_pkg::WD_VAL:   wr_data = val_reg;
            sle_pkg::WD_SHIFT: wr_data = rd_data_reg;
            default:           wr_data = value;
        endcase
    end

    assign wr_addr  = (cmd.wa_sel == sle_pkg::WA_POS) ? AW'(position) : idx_reg[AW-1:0];
    assign idx_plus = {1'b0, idx_reg} + 1'b1;

    assign stat.full       = (cnt_reg == CW'(CAPACITY));
    assign stat.empty      = (cnt_reg == '0);
    assign stat.pos_gt_cnt = (PW'(position) > PW'(cnt_reg));
    assign stat.pos_ge_cnt = (PW'(position) >= PW'(cnt_reg));
    assign stat.idx_eq_tgt = (idx_reg == tgt_reg);
    assign stat.idx_last   = (idx_plus >= {1'b0, cnt_reg});
    assign stat.idx_end    = (idx_reg == cnt_reg);
    assign stat.match      = (rd_data_reg == val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            tgt_reg <= sel_pos;
            val_reg <= value;
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            found_reg  <= cmd.res_found;
            fidx_reg   <= cmd.res_found ? 6'(idx_reg) : 6'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_rd)
            rd_data_reg <= mem[rd_addr];
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = fidx_reg;
    assign count       = 7'(cnt_reg);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == CW'($past(cnt_reg) + 1'b1)) ||
        (cnt_reg == CW'($past(cnt_reg) - 1'b1)))
        else $error("entry count moved by more than one");

    a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (PW'(wr_addr) <= PW'(cnt_reg)))
        else $error("write beyond end of list");

    a_inc_dec_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("count increment and decrement together");

endmodule

`default_nettype wire

>>> rtl/sequential_list_engine.sv
// Top level of the sequential list engine: controller and datapath.
`default_nettype none

// A transaction is taken at a clock edge with start high and busy low; its result shows
// on status, found, found_index and count for exactly one cycle with done high, and the
// receiver cannot stall it. The entries live in a memory that no state both reads and
// writes, so every entry that moves is read in a check state and written in the write
// state that follows. Pop back, amend and every refused operation give done in the cycle
// after the start and keep busy low. Push back, push front and insert move the entries
// from the target on up one place, then write the value; erase and pop front move the
// entries after the target down one place; find scans from index 0 to a match or the end.
module sequential_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [2:0]         action,
    input  wire logic [6:0]         position,
    input  wire logic signed [31:0] value,
    output logic                    busy,
    output logic                    done,
    output logic [1:0]              status,
    output logic                    found,
    output logic [5:0]              found_index,
    output logic [6:0]              count
);

    sle_pkg::sle_cmd_t  cmd;
    sle_pkg::sle_stat_t stat;

    sle_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .position    (position),
        .value       (value),
        .stat        (stat),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count       (count)
    );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the sequential list engine against a shadow list.
module tb_top;

    localparam int LIST_CAP       = 64;
    localparam int ITEM_TARGET    = 1400;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        sle_pkg::action_t op;
        logic [6:0]       pos;
        logic [31:0]      val;
    } list_op_t;

    typedef struct packed {
        sle_pkg::status_t rstat;
        logic             hit;
        logic [5:0]       hit_at;
        logic [6:0]       fill;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         action = sle_pkg::ACT_FIND;
    logic [6:0]         position = 7'd0;
    logic signed [31:0] value = 32'sd0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic               found;
    logic [5:0]         found_index;
    logic [6:0]         count;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];
    logic [31:0]  shadow_list[LIST_CAP];
    int           shadow_len = 0;
    int           n_queued = 0;
    int           n_accepted = 0;
    int           n_results = 0;
    int           n_issued = 0;
    int           errors = 0;
    int           quiet_cycles = 0;
    logic         taken = 1'b0;

    sequential_list_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .position    (position),
        .value       (value),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count       (count)
    );

    always #4 clk = ~clk;

    function automatic list_result_t apply_list_op(sle_pkg::action_t op, logic [6:0] pos,
                                                   logic [31:0] val);
        list_result_t r;
        int i;
        r = '0;
        r.rstat = sle_pkg::ST_OK;
        case (op)
            sle_pkg::ACT_PUSH_BACK:
            begin
                if (shadow_len >= LIST_CAP)
                    r.rstat = sle_pkg::ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                end
            end
            sle_pkg::ACT_POP_BACK:
            begin
                if (shadow_len == 0)
                    r.rstat = sle_pkg::ST_EMPTY;
                else
                    shadow_len--;
            end
            sle_pkg::ACT_PUSH_FRONT, sle_pkg::ACT_INSERT:
            begin
                if (shadow_len >= LIST_CAP)
                    r.rstat = sle_pkg::ST_FULL;
                else if (op == sle_pkg::ACT_INSERT && int'(pos) > shadow_len)
                    r.rstat = sle_pkg::ST_RANGE;
                else
                begin
                    if (op == sle_pkg::ACT_PUSH_FRONT)
                        pos = 7'd0;
                    for (i = shadow_len; i > int'(pos); i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos] = val;
                    shadow_len++;
                end
            end
            sle_pkg::ACT_POP_FRONT, sle_pkg::ACT_ERASE:
            begin
                if (op == sle_pkg::ACT_POP_FRONT)
                    pos = 7'd0;
                if (shadow_len == 0)
                    r.rstat = sle_pkg::ST_EMPTY;
                else if (int'(pos) >= shadow_len)
                    r.rstat = sle_pkg::ST_RANGE;
                else
                begin
                    for (i = int'(pos); i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            end
            sle_pkg::ACT_AMEND:
            begin
                if (shadow_len == 0)
                    r.rstat = sle_pkg::ST_EMPTY;
                else if (int'(pos) >= shadow_len)
                    r.rstat = sle_pkg::ST_RANGE;
                else
                    shadow_list[pos] = val;
            end
            default:
            begin
                for (i = 0; i < shadow_len; i++)
                begin
                    if (!r.hit && shadow_list[i] == val)
                    begin
                        r.hit = 1'b1;
                        r.hit_at = i[5:0];
                    end
                end
            end
        endcase
        r.fill = shadow_len[6:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_op(sle_pkg::action_t op, logic [6:0] pos, logic [31:0] val);
        pending_ops.push_back('{op, pos, val});
        n_queued++;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] corners[4];
        int sel;
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000};
        sel = int'($urandom_range(0, 3));
        if (sel < 2)
            return $urandom_range(0, 9) - 5;
        else if (sel == 2)
            return $urandom;
        return corners[2'($urandom_range(0, 3))];
    endfunction

    // Driver: hold a transaction until accepted, then advance or idle.
    always @(negedge clk)
    begin
        list_op_t nxt;
        logic     idle_ok;
        idle_ok = !(n_issued >= 500 && n_issued < 800);
        if (rst_n && (!start || taken))
        begin
            if (pending_ops.size() > 0 && !(idle_ok && $urandom_range(0, 99) < 17))
            begin
                nxt = pending_ops.pop_front();
                start <= 1'b1;
                action <= nxt.op;
                position <= nxt.pos;
                value <= nxt.val;
                n_issued <= n_issued + 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check results first, then record the transaction taken at this edge.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                n_results <= n_results + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.rstat), 32'(status));
                    check_field("found", 32'(want.hit), 32'(found));
                    check_field("found_index", 32'(want.hit_at), 32'(found_index));
                    check_field("count", 32'(want.fill), 32'(count));
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(
                    apply_list_op(sle_pkg::action_t'(action), position, value));
                n_accepted <= n_accepted + 1;
            end
            taken <= start && !busy;
        end
        else
            taken <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int               est;
        int               batch;
        int               blen;
        int               k;
        int               mode;
        int               pick;
        sle_pkg::action_t op;
        logic [6:0]       pos;
        logic [31:0]      val;

        queue_op(sle_pkg::ACT_FIND, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_POP_BACK, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_POP_FRONT, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_ERASE, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_AMEND, 7'd0, 32'd1);
        queue_op(sle_pkg::ACT_INSERT, 7'd1, 32'd1);
        queue_op(sle_pkg::ACT_INSERT, 7'd0, 32'h7fff_ffff);
        queue_op(sle_pkg::ACT_PUSH_BACK, 7'd64, 32'h8000_0000);
        queue_op(sle_pkg::ACT_PUSH_FRONT, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_PUSH_BACK, 7'd0, 32'hffff_ffff);
        queue_op(sle_pkg::ACT_INSERT, 7'd4, 32'd5);
        queue_op(sle_pkg::ACT_INSERT, 7'd2, 32'd5);
        queue_op(sle_pkg::ACT_FIND, 7'd0, 32'd5);
        queue_op(sle_pkg::ACT_FIND, 7'd0, 32'd12345);
        queue_op(sle_pkg::ACT_AMEND, 7'd5, 32'hffff_ffff);
        queue_op(sle_pkg::ACT_FIND, 7'd0, 32'hffff_ffff);
        queue_op(sle_pkg::ACT_AMEND, 7'd6, 32'd7);
        queue_op(sle_pkg::ACT_ERASE, 7'd6, 32'd0);
        queue_op(sle_pkg::ACT_ERASE, 7'd64, 32'd0);
        queue_op(sle_pkg::ACT_INSERT, 7'd64, 32'd9);
        queue_op(sle_pkg::ACT_ERASE, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_POP_FRONT, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_POP_BACK, 7'd0, 32'd0);
        queue_op(sle_pkg::ACT_FIND, 7'd0, 32'h8000_0000);
        queue_op(sle_pkg::ACT_AMEND, 7'd0, 32'h5555_5555);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        batch = 0;
        while (n_queued < ITEM_TARGET)
        begin
            do @(posedge clk); while (n_accepted != n_queued || n_results != n_queued);
            est = shadow_len;
            mode = batch % 8;
            blen = $urandom_range(16, 32);
            for (k = 0; k < blen; k++)
            begin
                pick = $urandom_range(0, 99);
                if (mode < 4)
                    op = pick < 30 ? sle_pkg::ACT_PUSH_BACK :
                         pick < 50 ? sle_pkg::ACT_PUSH_FRONT :
                         pick < 80 ? sle_pkg::ACT_INSERT :
                         pick < 85 ? sle_pkg::ACT_FIND :
                         pick < 90 ? sle_pkg::ACT_AMEND :
                         sle_pkg::action_t'($urandom_range(0, 7));
                else if (mode == 4)
                    op = pick < 40 ? sle_pkg::ACT_FIND :
                         pick < 65 ? sle_pkg::ACT_AMEND :
                         sle_pkg::action_t'($urandom_range(0, 7));
                else
                    op = pick < 25 ? sle_pkg::ACT_POP_BACK :
                         pick < 45 ? sle_pkg::ACT_POP_FRONT :
                         pick < 80 ? sle_pkg::ACT_ERASE :
                         pick < 85 ? sle_pkg::ACT_FIND :
                         sle_pkg::action_t'($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0)
                    pos = 7'($urandom_range(0, 64));
                else if (op == sle_pkg::ACT_INSERT)
                    pos = 7'($urandom_range(0, est));
                else if (op == sle_pkg::ACT_ERASE || op == sle_pkg::ACT_AMEND)
                    pos = est > 0 ? 7'($urandom_range(0, est - 1)) : 7'd0;
                else
                    pos = 7'($urandom_range(0, 64));
                val = pick_value();
                queue_op(op, pos, val);
                case (op)
                    sle_pkg::ACT_PUSH_BACK, sle_pkg::ACT_PUSH_FRONT:
                        if (est < LIST_CAP) est++;
                    sle_pkg::ACT_INSERT:
                        if (est < LIST_CAP && int'(pos) <= est) est++;
                    sle_pkg::ACT_POP_BACK, sle_pkg::ACT_POP_FRONT:
                        if (est > 0) est--;
                    sle_pkg::ACT_ERASE:
                        if (est > 0 && int'(pos) < est) est--;
                    default: ;
                endcase
            end
            batch++;
        end

        do @(posedge clk); while (n_accepted != n_queued || n_results != n_queued);
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

>>> filelist.f
rtl/sle_pkg.sv
rtl/sle_ctrl.sv
rtl/sle_datapath.sv
rtl/sequential_list_engine.sv
bench/tb_top.sv
